// ===== design/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and defaults of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package cau_pkg;

  localparam int DATA_WIDTH_D = 32;
  localparam int FRAC_BITS_D  = 16;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MULT  = 3'd2,
    OP_CONJ  = 3'd3,
    OP_NORM  = 3'd4,
    OP_SCALE = 3'd5,
    OP_DIV   = 3'd6,
    OP_MOVE  = 3'd7
  } op_t;

  // control that travels with each item
  typedef struct packed {
    logic vld;
    op_t  op;
    logic dz;
    logic neg_re;
    logic neg_im;
    logic ovq_re;
    logic ovq_im;
  } ctl_t;

endpackage
`default_nettype wire

// ===== design/cau_prod.sv =====
// ----------------------------------------------------------------------------
// cau_prod
// Product stage: six signed multipliers with operand selection per opcode.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_prod #(
  parameter int W = cau_pkg::DATA_WIDTH_D
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cau_pkg::ctl_t         ctl_i,
  input  wire logic signed [W-1:0]   ar_i,
  input  wire logic signed [W-1:0]   ai_i,
  input  wire logic signed [W-1:0]   br_i,
  input  wire logic signed [W-1:0]   bi_i,
  input  wire logic signed [W-1:0]   s_i,
  output cau_pkg::ctl_t              ctl_o,
  output logic signed [W-1:0]        ar_o,
  output logic signed [W-1:0]        ai_o,
  output logic signed [W-1:0]        br_o,
  output logic signed [W-1:0]        bi_o,
  output logic signed [2*W-1:0]      p0_o,
  output logic signed [2*W-1:0]      p1_o,
  output logic signed [2*W-1:0]      p2_o,
  output logic signed [2*W-1:0]      p3_o,
  output logic signed [2*W-1:0]      d0_o,
  output logic signed [2*W-1:0]      d1_o
);
  import cau_pkg::*;

  logic signed [W-1:0]   x0, x1;
  logic signed [2*W-1:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt, d0_nxt, d1_nxt;

  always_comb begin
    x0 = br_i;
    x1 = bi_i;
    if (ctl_i.op == OP_NORM) begin
      x0 = ar_i;
      x1 = ai_i;
    end else if (ctl_i.op == OP_SCALE) begin
      x0 = s_i;
      x1 = s_i;
    end
    p0_nxt = ar_i * x0;
    p1_nxt = ai_i * x1;
    p2_nxt = ar_i * bi_i;
    p3_nxt = ai_i * br_i;
    d0_nxt = br_i * br_i;
    d1_nxt = bi_i * bi_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.vld <= 1'b0;
    end else begin
      ctl_o.vld <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    ctl_o.op     <= ctl_i.op;
    ctl_o.dz     <= ctl_i.dz;
    ctl_o.neg_re <= ctl_i.neg_re;
    ctl_o.neg_im <= ctl_i.neg_im;
    ctl_o.ovq_re <= ctl_i.ovq_re;
    ctl_o.ovq_im <= ctl_i.ovq_im;
    ar_o <= ar_i;
    ai_o <= ai_i;
    br_o <= br_i;
    bi_o <= bi_i;
    p0_o <= p0_nxt;
    p1_o <= p1_nxt;
    p2_o <= p2_nxt;
    p3_o <= p3_nxt;
    d0_o <= d0_nxt;
    d1_o <= d1_nxt;
  end

endmodule
`default_nettype wire

// ===== design/cau_comb.sv =====
// ----------------------------------------------------------------------------
// cau_comb
// Two stages: sums per opcode, then divider setup (magnitude, range check).
// ----------------------------------------------------------------------------
`default_nettype none
module cau_comb #(
  parameter int W = cau_pkg::DATA_WIDTH_D,
  parameter int F = cau_pkg::FRAC_BITS_D
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cau_pkg::ctl_t              ctl_i,
  input  wire logic signed [W-1:0]        ar_i,
  input  wire logic signed [W-1:0]        ai_i,
  input  wire logic signed [W-1:0]        br_i,
  input  wire logic signed [W-1:0]        bi_i,
  input  wire logic signed [2*W-1:0]      p0_i,
  input  wire logic signed [2*W-1:0]      p1_i,
  input  wire logic signed [2*W-1:0]      p2_i,
  input  wire logic signed [2*W-1:0]      p3_i,
  input  wire logic signed [2*W-1:0]      d0_i,
  input  wire logic signed [2*W-1:0]      d1_i,
  output cau_pkg::ctl_t                   ctl_o,
  output logic signed [2*W+1:0]           val_re_o,
  output logic signed [2*W+1:0]           val_im_o,
  output logic [3*W+F+1:0]                rem_re_o,
  output logic [3*W+F+1:0]                rem_im_o,
  output logic [2*W-1:0]                  den_o
);
  import cau_pkg::*;

  localparam int SW = 2*W + 2;
  localparam int RW = 3*W + F + 2;

  logic signed [SW-1:0] sar, sai, sbr, sbi, s0, s1, s2, s3;
  logic signed [SW-1:0] re_nxt, im_nxt;
  logic [2*W-1:0]       den_nxt;

  ctl_t                 ca_r;
  logic signed [SW-1:0] re_r, im_r;
  logic [2*W-1:0]       den_r;

  logic [SW-1:0]        abs_re, abs_im;
  logic [RW-1:0]        n_re, n_im, den_sh;

  always_comb begin
    sar = SW'(ar_i);
    sai = SW'(ai_i);
    sbr = SW'(br_i);
    sbi = SW'(bi_i);
    s0  = SW'(p0_i);
    s1  = SW'(p1_i);
    s2  = SW'(p2_i);
    s3  = SW'(p3_i);
    den_nxt = d0_i + d1_i;
    unique case (ctl_i.op)
      OP_ADD: begin
        re_nxt = sar + sbr;
        im_nxt = sai + sbi;
      end
      OP_SUB: begin
        re_nxt = sar - sbr;
        im_nxt = sai - sbi;
      end
      OP_MULT: begin
        re_nxt = (s0 - s1) >>> F;
        im_nxt = (s2 + s3) >>> F;
      end
      OP_CONJ: begin
        re_nxt = sar;
        im_nxt = -sai;
      end
      OP_NORM: begin
        re_nxt = (s0 + s1) >>> F;
        im_nxt = '0;
      end
      OP_SCALE: begin
        re_nxt = s0 >>> F;
        im_nxt = s1 >>> F;
      end
      OP_DIV: begin
        re_nxt = s0 + s1;
        im_nxt = s3 - s2;
      end
      default: begin
        re_nxt = sar;
        im_nxt = sai;
      end
    endcase
  end

  // divider setup
  always_comb begin
    abs_re = re_r[SW-1] ? SW'(-re_r) : SW'(re_r);
    abs_im = im_r[SW-1] ? SW'(-im_r) : SW'(im_r);
    n_re   = RW'(abs_re) << F;
    n_im   = RW'(abs_im) << F;
    den_sh = RW'(den_r) << W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r.vld  <= 1'b0;
      ctl_o.vld <= 1'b0;
    end else begin
      ca_r.vld  <= ctl_i.vld;
      ctl_o.vld <= ca_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    ca_r.op     <= ctl_i.op;
    ca_r.dz     <= 1'b0;
    ca_r.neg_re <= 1'b0;
    ca_r.neg_im <= 1'b0;
    ca_r.ovq_re <= 1'b0;
    ca_r.ovq_im <= 1'b0;
    re_r  <= re_nxt;
    im_r  <= im_nxt;
    den_r <= den_nxt;

    ctl_o.op     <= ca_r.op;
    ctl_o.dz     <= (den_r == '0);
    ctl_o.neg_re <= re_r[SW-1];
    ctl_o.neg_im <= im_r[SW-1];
    ctl_o.ovq_re <= (n_re >= den_sh);
    ctl_o.ovq_im <= (n_im >= den_sh);
    val_re_o <= re_r;
    val_im_o <= im_r;
    rem_re_o <= n_re;
    rem_im_o <= n_im;
    den_o    <= den_r;
  end

endmodule
`default_nettype wire

// ===== design/cau_div_stage.sv =====
// ----------------------------------------------------------------------------
// cau_div_stage
// One restoring-division step: resolves quotient bit K of both parts.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_div_stage #(
  parameter int W = cau_pkg::DATA_WIDTH_D,
  parameter int F = cau_pkg::FRAC_BITS_D,
  parameter int K = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cau_pkg::ctl_t          ctl_i,
  input  wire logic signed [2*W+1:0]  val_re_i,
  input  wire logic signed [2*W+1:0]  val_im_i,
  input  wire logic [3*W+F+1:0]       rem_re_i,
  input  wire logic [3*W+F+1:0]       rem_im_i,
  input  wire logic [2*W-1:0]         den_i,
  input  wire logic [W-1:0]           q_re_i,
  input  wire logic [W-1:0]           q_im_i,
  output cau_pkg::ctl_t               ctl_o,
  output logic signed [2*W+1:0]       val_re_o,
  output logic signed [2*W+1:0]       val_im_o,
  output logic [3*W+F+1:0]            rem_re_o,
  output logic [3*W+F+1:0]            rem_im_o,
  output logic [2*W-1:0]              den_o,
  output logic [W-1:0]                q_re_o,
  output logic [W-1:0]                q_im_o
);
  import cau_pkg::*;

  localparam int RW = 3*W + F + 2;

  logic [RW-1:0] dsh, rre_nxt, rim_nxt;
  logic [W-1:0]  qre_nxt, qim_nxt;

  always_comb begin
    dsh     = RW'(den_i) << K;
    rre_nxt = rem_re_i;
    rim_nxt = rem_im_i;
    qre_nxt = q_re_i;
    qim_nxt = q_im_i;
    if (rem_re_i >= dsh) begin
      rre_nxt    = rem_re_i - dsh;
      qre_nxt[K] = 1'b1;
    end
    if (rem_im_i >= dsh) begin
      rim_nxt    = rem_im_i - dsh;
      qim_nxt[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.vld <= 1'b0;
    end else begin
      ctl_o.vld <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    ctl_o.op     <= ctl_i.op;
    ctl_o.dz     <= ctl_i.dz;
    ctl_o.neg_re <= ctl_i.neg_re;
    ctl_o.neg_im <= ctl_i.neg_im;
    ctl_o.ovq_re <= ctl_i.ovq_re;
    ctl_o.ovq_im <= ctl_i.ovq_im;
    val_re_o <= val_re_i;
    val_im_o <= val_im_i;
    rem_re_o <= rre_nxt;
    rem_im_o <= rim_nxt;
    den_o    <= den_i;
    q_re_o   <= qre_nxt;
    q_im_o   <= qim_nxt;
  end

endmodule
`default_nettype wire

// ===== design/cau_sat.sv =====
// ----------------------------------------------------------------------------
// cau_sat
// Output stage: signs the quotient, saturates both parts, sets flags.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_sat #(
  parameter int W = cau_pkg::DATA_WIDTH_D
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cau_pkg::ctl_t          ctl_i,
  input  wire logic signed [2*W+1:0]  val_re_i,
  input  wire logic signed [2*W+1:0]  val_im_i,
  input  wire logic [W-1:0]           q_re_i,
  input  wire logic [W-1:0]           q_im_i,
  output logic                        vld_o,
  output logic signed [W-1:0]         re_o,
  output logic signed [W-1:0]         im_o,
  output logic                        ovf_o,
  output logic                        dz_o
);
  import cau_pkg::*;

  localparam int SW = 2*W + 2;
  localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic signed [SW-1:0] vre, vim;
  logic signed [W-1:0]  re_nxt, im_nxt;
  logic                 ore, oim, dz_nxt;

  always_comb begin
    vre    = val_re_i;
    vim    = val_im_i;
    dz_nxt = 1'b0;
    if (ctl_i.op == OP_DIV) begin
      vre = ctl_i.neg_re ? -SW'(q_re_i) : SW'(q_re_i);
      vim = ctl_i.neg_im ? -SW'(q_im_i) : SW'(q_im_i);
      if (ctl_i.ovq_re) vre = ctl_i.neg_re ? MINV - 1 : MAXV + 1;
      if (ctl_i.ovq_im) vim = ctl_i.neg_im ? MINV - 1 : MAXV + 1;
      if (ctl_i.dz) begin
        vre    = '0;
        vim    = '0;
        dz_nxt = 1'b1;
      end
    end
    ore    = (vre > MAXV) || (vre < MINV);
    oim    = (vim > MAXV) || (vim < MINV);
    re_nxt = (vre > MAXV) ? MAXV[W-1:0] : (vre < MINV) ? MINV[W-1:0] : vre[W-1:0];
    im_nxt = (vim > MAXV) ? MAXV[W-1:0] : (vim < MINV) ? MINV[W-1:0] : vim[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    re_o  <= re_nxt;
    im_o  <= im_nxt;
    ovf_o <= ore || oim;
    dz_o  <= dz_nxt;
  end

endmodule
`default_nettype wire

// ===== design/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex ALU on signed fixed-point values with saturation.
// Every opcode passes the same stages: input register, product, combine,
// divider steps and output. Throughput: one item per cycle; busy is always
// low. Depth is set by the divider, one quotient bit per stage. Output strobe
// cannot be stalled. Reset clears all valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module complex_arith_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_D,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_D
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [2:0]                   in_op,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_im,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_im,
  input  wire logic signed [DATA_WIDTH-1:0] in_scale,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      out_res_re,
  output logic signed [DATA_WIDTH-1:0]      out_res_im,
  output logic                              out_overflow,
  output logic                              out_div_zero
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int SW = 2*W + 2;
  localparam int RW = 3*W + F + 2;

  ctl_t                 in_ctl_r;
  logic signed [W-1:0]  ar_r, ai_r, br_r, bi_r, s_r;

  ctl_t                 p_ctl;
  logic signed [W-1:0]  p_ar, p_ai, p_br, p_bi;
  logic signed [2*W-1:0] p0, p1, p2, p3, d0, d1;

  ctl_t                 ctl_s    [0:W];
  logic signed [SW-1:0] vre_s    [0:W];
  logic signed [SW-1:0] vim_s    [0:W];
  logic [RW-1:0]        rre_s    [0:W];
  logic [RW-1:0]        rim_s    [0:W];
  logic [2*W-1:0]       den_s    [0:W];
  logic [W-1:0]         qre_s    [0:W];
  logic [W-1:0]         qim_s    [0:W];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r.vld <= 1'b0;
    end else begin
      in_ctl_r.vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_ctl_r.op     <= op_t'(in_op);
    in_ctl_r.dz     <= 1'b0;
    in_ctl_r.neg_re <= 1'b0;
    in_ctl_r.neg_im <= 1'b0;
    in_ctl_r.ovq_re <= 1'b0;
    in_ctl_r.ovq_im <= 1'b0;
    ar_r <= in_a_re;
    ai_r <= in_a_im;
    br_r <= in_b_re;
    bi_r <= in_b_im;
    s_r  <= in_scale;
  end

  cau_prod #(.W(W)) u_prod (
    .clk(clk), .rst_n(rst_n), .ctl_i(in_ctl_r),
    .ar_i(ar_r), .ai_i(ai_r), .br_i(br_r), .bi_i(bi_r), .s_i(s_r),
    .ctl_o(p_ctl), .ar_o(p_ar), .ai_o(p_ai), .br_o(p_br), .bi_o(p_bi),
    .p0_o(p0), .p1_o(p1), .p2_o(p2), .p3_o(p3), .d0_o(d0), .d1_o(d1)
  );

  cau_comb #(.W(W), .F(F)) u_comb (
    .clk(clk), .rst_n(rst_n), .ctl_i(p_ctl),
    .ar_i(p_ar), .ai_i(p_ai), .br_i(p_br), .bi_i(p_bi),
    .p0_i(p0), .p1_i(p1), .p2_i(p2), .p3_i(p3), .d0_i(d0), .d1_i(d1),
    .ctl_o(ctl_s[0]), .val_re_o(vre_s[0]), .val_im_o(vim_s[0]),
    .rem_re_o(rre_s[0]), .rem_im_o(rim_s[0]), .den_o(den_s[0])
  );

  assign qre_s[0] = '0;
  assign qim_s[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_div
    cau_div_stage #(.W(W), .F(F), .K(W-1-i)) u_stage (
      .clk(clk), .rst_n(rst_n), .ctl_i(ctl_s[i]),
      .val_re_i(vre_s[i]), .val_im_i(vim_s[i]),
      .rem_re_i(rre_s[i]), .rem_im_i(rim_s[i]), .den_i(den_s[i]),
      .q_re_i(qre_s[i]), .q_im_i(qim_s[i]),
      .ctl_o(ctl_s[i+1]), .val_re_o(vre_s[i+1]), .val_im_o(vim_s[i+1]),
      .rem_re_o(rre_s[i+1]), .rem_im_o(rim_s[i+1]), .den_o(den_s[i+1]),
      .q_re_o(qre_s[i+1]), .q_im_o(qim_s[i+1])
    );
  end

  cau_sat #(.W(W)) u_sat (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl_s[W]),
    .val_re_i(vre_s[W]), .val_im_i(vim_s[W]),
    .q_re_i(qre_s[W]), .q_im_i(qim_s[W]),
    .vld_o(out_valid), .re_o(out_res_re), .im_o(out_res_im),
    .ovf_o(out_overflow), .dz_o(out_div_zero)
  );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for complex_arith_unit. Drives directed corner items
// and random items with random start gaps. A scoreboard predicts each
// result in wide signed arithmetic and compares every output strobe in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module testbench;
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH_D;
  localparam int FB = FRAC_BITS_D;
  localparam int LATENCY = DW + 5;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    word_t re;
    word_t im;
    logic  ovf;
    logic  dz;
  } cplx_res_t;

  class cplx_scoreboard;
    cplx_res_t pending[$];
    int errors;
    int items;
    int results;
    int op_count[8];
    int ovf_count;
    int dz_count;

    function automatic word_t clamp(wide_t v, ref logic ovf);
      wide_t hi_lim;
      wide_t lo_lim;
      hi_lim = (wide_t'(1) <<< (DW - 1)) - 1;
      lo_lim = -(wide_t'(1) <<< (DW - 1));
      if (v > hi_lim) begin
        ovf = 1'b1;
        return word_t'(hi_lim);
      end
      if (v < lo_lim) begin
        ovf = 1'b1;
        return word_t'(lo_lim);
      end
      return word_t'(v);
    endfunction

    function automatic cplx_res_t compute(op_t op, word_t ar, word_t ai, word_t br,
                                          word_t bi, word_t s);
      wide_t xr, xi, yr, yi, sv, vr, vi, den;
      cplx_res_t r;
      logic ovf;
      xr = ar; xi = ai; yr = br; yi = bi; sv = s;
      vr = xr; vi = xi;
      ovf = 1'b0;
      r.dz = 1'b0;
      case (op)
        OP_ADD: begin vr = xr + yr; vi = xi + yi; end
        OP_SUB: begin vr = xr - yr; vi = xi - yi; end
        OP_MULT: begin
          vr = (xr * yr - xi * yi) >>> FB;
          vi = (xr * yi + xi * yr) >>> FB;
        end
        OP_CONJ: vi = -xi;
        OP_NORM: begin vr = (xr * xr + xi * xi) >>> FB; vi = 0; end
        OP_SCALE: begin vr = (xr * sv) >>> FB; vi = (xi * sv) >>> FB; end
        OP_DIV: begin
          den = yr * yr + yi * yi;
          if (den == 0) begin
            r.dz = 1'b1;
            vr = 0;
            vi = 0;
          end else begin
            vr = ((xr * yr + xi * yi) <<< FB) / den;
            vi = ((xi * yr - xr * yi) <<< FB) / den;
          end
        end
        default: ;
      endcase
      r.re = clamp(vr, ovf);
      r.im = clamp(vi, ovf);
      r.ovf = ovf;
      return r;
    endfunction

    function void note(op_t op, word_t ar, word_t ai, word_t br, word_t bi, word_t s);
      cplx_res_t r;
      r = compute(op, ar, ai, br, bi, s);
      pending.push_back(r);
      items++;
      op_count[op]++;
      if (r.ovf) ovf_count++;
      if (r.dz) dz_count++;
    endfunction

    function void check(word_t re, word_t im, logic ovf, logic dz);
      cplx_res_t e;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h ovf=%b dz=%b", $time, re, im, ovf, dz);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (re !== e.re) begin
        $display("%0t: res_re expected %h actual %h", $time, e.re, re);
        errors++;
      end
      if (im !== e.im) begin
        $display("%0t: res_im expected %h actual %h", $time, e.im, im);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflow expected %b actual %b", $time, e.ovf, ovf);
        errors++;
      end
      if (dz !== e.dz) begin
        $display("%0t: div_zero expected %b actual %b", $time, e.dz, dz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [2:0] in_op = '0;
  word_t in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0, in_scale = '0;
  logic busy, out_valid, out_overflow, out_div_zero;
  word_t out_res_re, out_res_im;

  cplx_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  complex_arith_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im), .in_scale(in_scale),
    .out_valid(out_valid), .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_overflow(out_overflow), .out_div_zero(out_div_zero)
  );

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note(op_t'(in_op), in_a_re, in_a_im, in_b_re, in_b_im, in_scale);
    if (rst_n && out_valid)
      sb.check(out_res_re, out_res_im, out_overflow, out_div_zero);
  end

  task automatic send_item(op_t op, word_t ar, word_t ai, word_t br, word_t bi, word_t s);
    in_op <= op;
    in_a_re <= ar; in_a_im <= ai;
    in_b_re <= br; in_b_im <= bi;
    in_scale <= s;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 99) < 60) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 3)) == 0 ? {1'b1, {(DW-1){1'b0}}} :
                word_t'($urandom_range(0, 1)) ? {1'b0, {(DW-1){1'b1}}} : '0;
      2: return word_t'($signed($urandom) >>> 8);
      default: return word_t'($signed($urandom) >>> $urandom_range(10, 20));
    endcase
  endfunction

  localparam word_t MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(DW-1){1'b0}}};
  localparam word_t ONE = word_t'(1) <<< FB;

  initial begin
    int k;
    op_t op;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed corners
    send_item(OP_ADD, MAXV, MINV, MAXV, MINV, 0);
    send_item(OP_SUB, MINV, MAXV, MAXV, MINV, 0);
    send_item(OP_ADD, ONE, -ONE, -ONE, ONE, 0);
    send_item(OP_MULT, MAXV, MAXV, MAXV, MINV, 0);
    send_item(OP_MULT, MINV, MINV, MINV, MINV, 0);
    send_item(OP_MULT, -1, 3, 1, -1, 0);
    send_item(OP_CONJ, MINV, MINV, 0, 0, 0);
    send_item(OP_CONJ, MAXV, MAXV, 0, 0, 0);
    send_item(OP_NORM, MINV, MINV, 5, 5, 5);
    send_item(OP_NORM, ONE, ONE, 0, 0, 0);
    send_item(OP_SCALE, MAXV, MINV, 0, 0, MINV);
    send_item(OP_SCALE, -3, 7, 0, 0, ONE >>> 1);
    send_item(OP_DIV, ONE, ONE, 0, 0, 0);
    send_item(OP_DIV, MAXV, MINV, 0, 0, MAXV);
    send_item(OP_DIV, MAXV, MAXV, 1, 0, 0);
    send_item(OP_DIV, -7, 5, ONE, -ONE, 0);
    send_item(OP_DIV, MINV, MINV, MINV, MINV, 0);
    send_item(OP_DIV, 1, -1, MAXV, MAXV, 0);
    send_item(OP_MOVE, MINV, MAXV, MAXV, MINV, MAXV);
    send_item(OP_MOVE, -1, 0, 0, 0, 0);
    for (k = 0; k < 800; k++) begin
      idle_gap();
      op = op_t'($urandom_range(0, 7));
      if (op == OP_DIV && $urandom_range(0, 9) == 0)
        send_item(op, rand_word(), rand_word(), 0, 0, rand_word());
      else
        send_item(op, rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d items, %0d results; saturated %0d, zero divisor %0d",
             sb.items, sb.results, sb.ovf_count, sb.dz_count);
    $display("per op: add %0d sub %0d mult %0d conj %0d norm %0d scale %0d div %0d move %0d",
             sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3],
             sb.op_count[4], sb.op_count[5], sb.op_count[6], sb.op_count[7]);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
